// ===== hw/rtl/cssd_pkg.sv =====
package cssd_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int MAX_ROWS        = 1024;

    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 10;
    localparam int SUM_W   = 11;
    localparam int FIFO_DEPTH = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLUMNS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STAR_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_COLUMNS_RST  = 11'd26;
    localparam logic [CFG_W-1:0] FRAME_ROWS_RST     = 11'd9;
    localparam logic [CFG_W-1:0] STAR_THRESHOLD_RST = 11'd30;

    localparam int MIN_SIZE = 3;

    typedef struct packed {
        logic             star_found;
        logic [POS_W-1:0] center_row;
        logic [POS_W-1:0] center_column;
        logic             frame_last;
    } result_t;

endpackage

// ===== hw/rtl/cssd_line_store.sv =====
module cssd_line_store #(
    parameter int MAX_COLUMNS = cssd_pkg::MAX_COLUMNS_DEF,
    parameter int CW          = $clog2(MAX_COLUMNS)
) (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [CW-1:0]              rd_addr,
    input  logic                       wr_en,
    input  logic [CW-1:0]              wr_addr,
    input  logic [cssd_pkg::PIX_W-1:0] wr_pix,
    output logic [cssd_pkg::PIX_W-1:0] up_data,
    output logic [cssd_pkg::PIX_W-1:0] mid_data
);

    logic [cssd_pkg::PIX_W-1:0] older_mem [MAX_COLUMNS];
    logic [cssd_pkg::PIX_W-1:0] newer_mem [MAX_COLUMNS];
    logic [cssd_pkg::PIX_W-1:0] up_reg;
    logic [cssd_pkg::PIX_W-1:0] mid_reg;

    // the middle row moves up into the older store when the new pixel lands
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_mem[wr_addr] <= mid_reg;
        end
        if (rd_en) begin
            up_reg <= older_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            newer_mem[wr_addr] <= wr_pix;
        end
        if (rd_en) begin
            mid_reg <= newer_mem[rd_addr];
        end
    end

    assign up_data  = up_reg;
    assign mid_data = mid_reg;

endmodule

// ===== hw/rtl/cssd_out_fifo.sv =====
module cssd_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cssd_pkg::result_t push_data,
    input  logic              pop,
    output logic              not_empty,
    output logic [1:0]        occupancy,
    output cssd_pkg::result_t head_data
);

    cssd_pkg::result_t entry_reg [cssd_pkg::FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        logic [1:0] r;
        r = (p == 2'(cssd_pkg::FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != 2'd0);
    assign occupancy = count_reg;
    assign head_data = entry_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/cross_stencil_star_detect.sv =====
// Channel  | Dir | Fields (low bit up)                          | Flow
// s_       | in  | tdata: pixel_value[7:0]                      | one pixel per transaction
// m_       | out | tdata: center_row[9:0], center_column[19:10] | one per interior pixel
//          |     | tuser: star_found, tlast: frame_last         |
// cfg_wr_  | in  | index 0 columns, 1 rows, 2 threshold         | write only
// One pixel per cycle while s_tready is high; each result is pushed into the output queue
// from the registered input stage. Each row store has a single read and write port.
// The three-entry output queue lets input keep flowing while a result waits; input
// stalls only when the queue plus the item in flight would fill it.
// Synchronous reset loads config defaults and clears positions, window and queue; row stores are not cleared.
module cross_stencil_star_detect #(
    parameter int MAX_COLUMNS = cssd_pkg::MAX_COLUMNS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // pixel_value[7:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // center_row[9:0], center_column[19:10]
    output logic                           m_tuser,   // star_found
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [cssd_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [cssd_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int XW = (CW + 1 > cssd_pkg::CFG_W) ? CW + 1 : cssd_pkg::CFG_W;
    localparam logic [XW-1:0] MAX_COLS_X = XW'(MAX_COLUMNS);
    localparam logic [cssd_pkg::CFG_W-1:0] MAX_ROWS_X = cssd_pkg::CFG_W'(cssd_pkg::MAX_ROWS);

    localparam int PW = cssd_pkg::PIX_W;
    localparam int QW = cssd_pkg::POS_W;

    logic [cssd_pkg::CFG_W-1:0] frame_columns_reg;
    logic [cssd_pkg::CFG_W-1:0] frame_rows_reg;
    logic [cssd_pkg::CFG_W-1:0] star_threshold_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [QW-1:0] row_reg, row_next;

    logic [XW-1:0] fc_x, cols_x;
    logic [cssd_pkg::CFG_W-1:0] rows_e;
    logic last_col, last_row;
    logic accept, emit, size_write;
    logic [CW-1:0] col_m1;

    logic          v1_reg;
    logic [PW-1:0] pix1_reg;
    logic [CW-1:0] col1_reg;
    logic          emit1_reg;
    logic [QW-1:0] crow1_reg;
    logic [QW-1:0] ccol1_reg;
    logic          last1_reg;

    logic [PW-1:0] w4_reg, w6_reg, w7_reg, w8_reg;
    logic [PW-1:0] up_data, mid_data;
    logic [cssd_pkg::SUM_W-1:0] cross_sum;

    logic              fifo_push, fifo_pop, fifo_not_empty;
    logic [1:0]        fifo_occ;
    logic [2:0]        fifo_load;
    cssd_pkg::result_t push_item, head_item;

    // clamped frame size
    always_comb begin
        fc_x = XW'(frame_columns_reg);
        if (fc_x < XW'(cssd_pkg::MIN_SIZE)) begin
            cols_x = XW'(cssd_pkg::MIN_SIZE);
        end else if (fc_x > MAX_COLS_X) begin
            cols_x = MAX_COLS_X;
        end else begin
            cols_x = fc_x;
        end
        if (frame_rows_reg < cssd_pkg::CFG_W'(cssd_pkg::MIN_SIZE)) begin
            rows_e = cssd_pkg::CFG_W'(cssd_pkg::MIN_SIZE);
        end else if (frame_rows_reg > MAX_ROWS_X) begin
            rows_e = MAX_ROWS_X;
        end else begin
            rows_e = frame_rows_reg;
        end
    end

    assign last_col   = (XW'(col_reg) == cols_x - XW'(1));
    assign last_row   = ({1'b0, row_reg} == rows_e - cssd_pkg::CFG_W'(1));
    assign fifo_load  = {1'b0, fifo_occ} + {2'b00, v1_reg & emit1_reg};
    assign s_tready   = (fifo_load <= 3'(cssd_pkg::FIFO_DEPTH - 1));
    assign accept     = s_tvalid & s_tready;
    assign emit       = (row_reg >= QW'(2)) && (col_reg >= CW'(2));
    assign col_m1     = col_reg - CW'(1);
    assign size_write = cfg_wr_en && ((cfg_wr_index == cssd_pkg::REG_FRAME_COLUMNS) ||
                                      (cfg_wr_index == cssd_pkg::REG_FRAME_ROWS));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (size_write) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + QW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_columns_reg  <= cssd_pkg::FRAME_COLUMNS_RST;
            frame_rows_reg     <= cssd_pkg::FRAME_ROWS_RST;
            star_threshold_reg <= cssd_pkg::STAR_THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                cssd_pkg::REG_FRAME_COLUMNS:  frame_columns_reg  <= cfg_wr_data;
                cssd_pkg::REG_FRAME_ROWS:     frame_rows_reg     <= cfg_wr_data;
                cssd_pkg::REG_STAR_THRESHOLD: star_threshold_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            v1_reg  <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg  <= s_tdata[PW-1:0];
            col1_reg  <= col_reg;
            emit1_reg <= emit;
            crow1_reg <= row_reg - QW'(1);
            ccol1_reg <= QW'(col_m1);
            last1_reg <= last_row && last_col;
        end
    end

    cssd_line_store #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CW          (CW)
    ) u_line_store (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_addr  (col_reg),
        .wr_en    (v1_reg),
        .wr_addr  (col1_reg),
        .wr_pix   (pix1_reg),
        .up_data  (up_data),
        .mid_data (mid_data)
    );

    // w6/w7/w8: newest column (up, mid, pixel); w4: middle row one column back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w4_reg <= '0;
            w6_reg <= '0;
            w7_reg <= '0;
            w8_reg <= '0;
        end else if (v1_reg) begin
            w4_reg <= w7_reg;
            w6_reg <= up_data;
            w7_reg <= mid_data;
            w8_reg <= pix1_reg;
        end
    end

    assign cross_sum = cssd_pkg::SUM_W'(w6_reg) + cssd_pkg::SUM_W'(w7_reg)
                     + cssd_pkg::SUM_W'(w8_reg) + cssd_pkg::SUM_W'(w4_reg)
                     + cssd_pkg::SUM_W'(mid_data);

    always_comb begin
        push_item.star_found    = (cross_sum > star_threshold_reg);
        push_item.center_row    = crow1_reg;
        push_item.center_column = ccol1_reg;
        push_item.frame_last    = last1_reg;
    end

    assign fifo_push = v1_reg & emit1_reg;
    assign fifo_pop  = fifo_not_empty & m_tready;

    cssd_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data (push_item),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .occupancy (fifo_occ),
        .head_data (head_item)
    );

    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = {4'b0000, head_item.center_column, head_item.center_row};
    assign m_tuser  = head_item.star_found;
    assign m_tlast  = head_item.frame_last;

endmodule
